@@ hdl/tcw_pkg.sv @@
`default_nettype none

package tcw_pkg;

    // request kinds carried in s_tuser
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // configuration register indexes
    localparam logic REG_FOREGROUND = 1'b0;
    localparam logic REG_BACKGROUND = 1'b1;

    // colour reset values
    localparam logic [3:0] FOREGROUND_RESET = 4'h7;
    localparam logic [3:0] BACKGROUND_RESET = 4'h0;

    // character codes
    localparam logic [7:0] NUL_CODE     = 8'h00;
    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] SPACE_CODE   = 8'h20;

    // fixed field widths
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int INDEX_W  = 11;
    localparam int CELL_W   = CHAR_W + ATTR_W;

    // one result, cell_char in the lowest bits
    typedef struct packed {
        logic [INDEX_W-1:0] cursor_position;
        logic [ATTR_W-1:0]  cell_attribute;
        logic [CHAR_W-1:0]  cell_char;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SWEEP
    } ctrl_state_t;

endpackage

`default_nettype wire

@@ hdl/tcw_ram.sv @@
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ hdl/tcw_ctrl.sv @@
`default_nettype none

module tcw_ctrl #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [1:0]                           mode,
    input  wire logic [tcw_pkg::CHAR_W-1:0]           char_code,
    input  wire logic [tcw_pkg::INDEX_W-1:0]          cell_index,
    input  wire logic [tcw_pkg::ATTR_W-1:0]           attribute,
    input  wire logic                                 out_free,
    output logic                                      res_load,
    output tcw_pkg::result_t                          res,
    output logic                                      mem_we,
    output logic [$clog2(COLUMNS*ROWS)-1:0]           mem_waddr,
    output logic [tcw_pkg::CELL_W-1:0]                mem_wdata,
    output logic [$clog2(COLUMNS*ROWS)-1:0]           mem_raddr,
    input  wire logic [tcw_pkg::CELL_W-1:0]           mem_rdata
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int AW1        = AW + 1;
    localparam int LW         = $clog2(CELL_COUNT + 1);
    localparam int CLW        = $clog2(COLUMNS);
    localparam int CW         = ((AW > tcw_pkg::INDEX_W) ? AW : tcw_pkg::INDEX_W) + 1;
    localparam logic [AW-1:0]  LAST_LINE  = AW'((ROWS - 1) * COLUMNS);
    localparam logic [AW-1:0]  ROW_STEP   = AW'(COLUMNS);
    localparam logic [AW1-1:0] CELLS_WIDE = AW1'(CELL_COUNT);
    localparam logic [CLW-1:0] LAST_COL   = CLW'(COLUMNS - 1);

    tcw_pkg::ctrl_state_t state_reg, state_next;

    logic [AW-1:0]             cursor_reg, cursor_next;
    logic [CLW-1:0]            col_reg, col_next;
    logic [AW-1:0]             line_reg, line_next;
    logic [AW-1:0]             base_reg, base_next;
    logic [AW-1:0]             sweep_addr_reg, sweep_addr_next;
    logic [LW-1:0]             sweep_left_reg, sweep_left_next;
    logic [AW-1:0]             raddr_reg, raddr_next;
    logic                      in_range_reg, in_range_next;
    logic [tcw_pkg::CELL_W-1:0] blank_reg, blank_next;

    logic          accept;
    logic          is_write;
    logic          is_newline;
    logic          is_glyph;
    logic          last_line;
    logic          scroll_req;
    logic [CW-1:0] idx_wide;
    logic          idx_in_range;
    logic [AW1-1:0] rd_sum;
    logic [AW1-1:0] wr_sum;
    logic [AW-1:0]  rd_phys;
    logic [AW-1:0]  wr_phys;
    logic [AW-1:0]  base_step;

    assign s_tready = (state_reg == tcw_pkg::ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    // request decode
    always_comb begin
        is_write     = (mode == tcw_pkg::MODE_WRITE);
        is_newline   = is_write && (char_code == tcw_pkg::NEWLINE_CODE);
        is_glyph     = is_write && (char_code != tcw_pkg::NEWLINE_CODE)
                       && (char_code != tcw_pkg::NUL_CODE);
        last_line    = (line_reg == LAST_LINE);
        scroll_req   = last_line && (is_newline || (is_glyph && (col_reg == LAST_COL)));
        idx_wide     = CW'(cell_index);
        idx_in_range = (idx_wide < CW'(CELL_COUNT));
    end

    // logical to physical address through the rotating row base
    always_comb begin
        rd_sum    = {1'b0, AW'(idx_wide)} + {1'b0, base_reg};
        wr_sum    = {1'b0, cursor_reg} + {1'b0, base_reg};
        rd_phys   = (rd_sum >= CELLS_WIDE) ? AW'(rd_sum - CELLS_WIDE) : AW'(rd_sum);
        wr_phys   = (wr_sum >= CELLS_WIDE) ? AW'(wr_sum - CELLS_WIDE) : AW'(wr_sum);
        base_step = (base_reg == LAST_LINE) ? '0 : base_reg + ROW_STEP;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tcw_pkg::ST_IDLE: begin
                if (accept) begin
                    if (mode == tcw_pkg::MODE_READ) begin
                        state_next = tcw_pkg::ST_READ;
                    end else if (mode == tcw_pkg::MODE_CLEAR || scroll_req) begin
                        state_next = tcw_pkg::ST_SWEEP;
                    end
                end
            end
            tcw_pkg::ST_READ: begin
                if (out_free) begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_SWEEP: begin
                if (sweep_left_reg == LW'(1)) begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            default: state_next = tcw_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory port
    always_comb begin
        cursor_next     = cursor_reg;
        col_next        = col_reg;
        line_next       = line_reg;
        base_next       = base_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_left_next = sweep_left_reg;
        raddr_next      = raddr_reg;
        in_range_next   = in_range_reg;
        blank_next      = blank_reg;
        mem_we          = 1'b0;
        mem_waddr       = wr_phys;
        mem_wdata       = {attribute, char_code};
        mem_raddr       = raddr_reg;
        res_load        = 1'b0;
        res             = '0;

        unique case (state_reg)
            tcw_pkg::ST_IDLE: begin
                mem_raddr = rd_phys;
                if (accept) begin
                    case (mode)
                        tcw_pkg::MODE_WRITE: begin
                            if (is_newline) begin
                                col_next = '0;
                                if (last_line) begin
                                    cursor_next = LAST_LINE;
                                end else begin
                                    line_next   = line_reg + ROW_STEP;
                                    cursor_next = line_reg + ROW_STEP;
                                end
                            end else if (is_glyph) begin
                                mem_we      = 1'b1;
                                cursor_next = cursor_reg + AW'(1);
                                col_next    = col_reg + CLW'(1);
                                if (col_reg == LAST_COL) begin
                                    col_next = '0;
                                    if (last_line) begin
                                        cursor_next = LAST_LINE;
                                    end else begin
                                        line_next = line_reg + ROW_STEP;
                                    end
                                end
                            end
                            // scroll: old top row becomes the blank bottom row
                            if (scroll_req) begin
                                sweep_addr_next = base_reg;
                                sweep_left_next = LW'(COLUMNS);
                                base_next       = base_step;
                                blank_next      = {attribute, tcw_pkg::SPACE_CODE};
                            end
                        end
                        tcw_pkg::MODE_CLEAR: begin
                            cursor_next     = '0;
                            col_next        = '0;
                            line_next       = '0;
                            base_next       = '0;
                            sweep_addr_next = '0;
                            sweep_left_next = LW'(CELL_COUNT);
                            blank_next      = {attribute, tcw_pkg::SPACE_CODE};
                        end
                        tcw_pkg::MODE_READ: begin
                            raddr_next    = rd_phys;
                            in_range_next = idx_in_range;
                        end
                        default: begin
                        end
                    endcase
                    if (mode != tcw_pkg::MODE_READ) begin
                        res_load            = 1'b1;
                        res.cursor_position = tcw_pkg::INDEX_W'(cursor_next);
                    end
                end
            end
            tcw_pkg::ST_READ: begin
                if (out_free) begin
                    res_load            = 1'b1;
                    res.cursor_position = tcw_pkg::INDEX_W'(cursor_reg);
                    if (in_range_reg) begin
                        res.cell_char      = mem_rdata[tcw_pkg::CHAR_W-1:0];
                        res.cell_attribute = mem_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
                    end
                end
            end
            tcw_pkg::ST_SWEEP: begin
                mem_we          = 1'b1;
                mem_waddr       = sweep_addr_reg;
                mem_wdata       = blank_reg;
                sweep_addr_next = sweep_addr_reg + AW'(1);
                sweep_left_next = sweep_left_reg - LW'(1);
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= tcw_pkg::ST_IDLE;
            cursor_reg     <= '0;
            col_reg        <= '0;
            line_reg       <= '0;
            base_reg       <= '0;
            sweep_left_reg <= '0;
        end else begin
            state_reg      <= state_next;
            cursor_reg     <= cursor_next;
            col_reg        <= col_next;
            line_reg       <= line_next;
            base_reg       <= base_next;
            sweep_left_reg <= sweep_left_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        sweep_addr_reg <= sweep_addr_next;
        raddr_reg      <= raddr_next;
        in_range_reg   <= in_range_next;
        blank_reg      <= blank_next;
    end

endmodule

`default_nettype wire

@@ hdl/text_console_writer.sv @@
// Text console writer: a character-cell screen of COLUMNS x ROWS cells.
// Input channel (s_*): s_tuser carries the request kind (write byte, clear
// screen, read cell); s_tdata carries the character byte and the cell index.
// Result channel (m_*): exactly one result per request, holding the cell
// character and attribute (zero unless a read) and the cursor after the request.
// Configuration: cfg_wen writes the foreground or background colour nibble.
// A write, newline, clear or unused request has its result in the output
// register in the cycle after acceptance; a read passes through the cell
// memory's registered read port and then the output register.
// Throughput: one plain write or newline per cycle while results are taken;
// a read holds the input until its result is loaded. A scroll stalls the
// input while the bottom row is blanked (rows rotate through a base pointer,
// so only one row is rewritten); a clear stalls it while all COLUMNS*ROWS
// cells are blanked, one cell per cycle through the memory's write port.
// Reset: cursor home, colours foreground 7 and background 0; the screen holds
// no defined contents until the first clear request.
// A stalled receiver holds the result in the output register; a new request is
// taken only when that register is empty or being emptied in the same cycle.
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // char_code [7:0], cell_index [18:8], zero [23:19]
    input  wire logic [1:0]  s_tuser,   // mode [1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // cell_char [7:0], cell_attribute [15:8],
                                        // cursor_position [26:16], zero [31:27]
    input  wire logic        cfg_wen,
    input  wire logic        cfg_addr,
    input  wire logic [3:0]  cfg_wdata
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int AW         = $clog2(CELL_COUNT);

    logic [3:0] fg_reg, fg_next;
    logic [3:0] bg_reg, bg_next;
    logic       m_valid_reg, m_valid_next;
    tcw_pkg::result_t m_data_reg, m_data_next;

    logic                        out_free;
    logic                        res_load;
    tcw_pkg::result_t            res;
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [tcw_pkg::CELL_W-1:0]  mem_wdata;
    logic [AW-1:0]               mem_raddr;
    logic [tcw_pkg::CELL_W-1:0]  mem_rdata;

    // colour registers
    always_comb begin
        fg_next = fg_reg;
        bg_next = bg_reg;
        if (cfg_wen) begin
            unique case (cfg_addr)
                tcw_pkg::REG_FOREGROUND: fg_next = cfg_wdata;
                tcw_pkg::REG_BACKGROUND: bg_next = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // output register
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_load) begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg      <= tcw_pkg::FOREGROUND_RESET;
            bg_reg      <= tcw_pkg::BACKGROUND_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            fg_reg      <= fg_next;
            bg_reg      <= bg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_data_reg};

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .mode       (s_tuser),
        .char_code  (s_tdata[7:0]),
        .cell_index (s_tdata[18:8]),
        .attribute  ({bg_reg, fg_reg}),
        .out_free   (out_free),
        .res_load   (res_load),
        .res        (res),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_cells (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

endmodule

`default_nettype wire
